// ===== rtl/core/i2cmw_pkg.sv =====
`default_nettype none

package i2cmw_pkg;

    localparam int unsigned DataWidth  = 8;
    localparam int unsigned MaskWidth  = 3;
    localparam int unsigned BitWidth   = 3;
    localparam int unsigned ByteWidth  = 2;
    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned BusWidth   = 32;

    localparam logic [DataWidth-1:0] AddressReset = 8'd120;
    localparam logic [DataWidth-1:0] DelayReset   = 8'd10;
    localparam logic [DataWidth-1:0] CtrlCommand  = 8'h00;
    localparam logic [DataWidth-1:0] CtrlData     = 8'h40;
    localparam logic [BitWidth-1:0]  LastBit      = 3'd7;
    localparam logic [ByteWidth-1:0] LastByte     = 2'd2;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_DEVICE_ADDRESS = 1'b0,
        REG_DELAY_TICKS    = 1'b1
    } reg_index_t;

    typedef enum logic [3:0]
    {
        PH_IDLE = 4'd0,
        PH_S1   = 4'd1,
        PH_S2   = 4'd2,
        PH_S3   = 4'd3,
        PH_B1   = 4'd4,
        PH_B2   = 4'd5,
        PH_B3   = 4'd6,
        PH_A1   = 4'd7,
        PH_A2   = 4'd8,
        PH_A3   = 4'd9,
        PH_P1   = 4'd10
    } phase_t;

    typedef struct packed
    {
        logic [DataWidth-1:0] device_address;
        logic [DataWidth-1:0] delay_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cmw_regs.sv =====
`default_nettype none

module i2cmw_regs
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [i2cmw_pkg::AddrWidth-1:0]     paddr,
    input  wire logic [i2cmw_pkg::BusWidth-1:0]      pwdata,
    output logic      [i2cmw_pkg::BusWidth-1:0]      prdata,
    output logic                                     pready,
    output i2cmw_pkg::cfg_t                          cfg
);

    logic [i2cmw_pkg::DataWidth-1:0] address_reg;
    logic [i2cmw_pkg::DataWidth-1:0] delay_reg;
    logic                            wr_en;
    i2cmw_pkg::reg_index_t           index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = i2cmw_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= i2cmw_pkg::AddressReset;
            delay_reg   <= i2cmw_pkg::DelayReset;
        end
        else if (wr_en)
        begin
            case (index)
                i2cmw_pkg::REG_DEVICE_ADDRESS: address_reg <= pwdata[i2cmw_pkg::DataWidth-1:0];
                i2cmw_pkg::REG_DELAY_TICKS:    delay_reg   <= pwdata[i2cmw_pkg::DataWidth-1:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            i2cmw_pkg::REG_DEVICE_ADDRESS:
                prdata = {{(i2cmw_pkg::BusWidth-i2cmw_pkg::DataWidth){1'b0}}, address_reg};
            i2cmw_pkg::REG_DELAY_TICKS:
                prdata = {{(i2cmw_pkg::BusWidth-i2cmw_pkg::DataWidth){1'b0}}, delay_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.device_address = address_reg;
    assign cfg.delay_ticks    = delay_reg;

endmodule

`default_nettype wire

// ===== rtl/core/i2cmw_core.sv =====
`default_nettype none

module i2cmw_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire i2cmw_pkg::cfg_t                     cfg,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                start_req,
    input  wire logic                                func,
    input  wire logic [i2cmw_pkg::DataWidth-1:0]     payload,
    input  wire logic                                sda_in,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     scl_level,
    output logic                                     sda_level,
    output logic                                     busy_res,
    output logic                                     done_res,
    output logic      [i2cmw_pkg::MaskWidth-1:0]     nack_mask
);

    i2cmw_pkg::phase_t               phase_reg,   phase_next;
    logic [i2cmw_pkg::DataWidth-1:0] tick_reg,    tick_next;
    logic [i2cmw_pkg::BitWidth-1:0]  bit_reg,     bit_next;
    logic [i2cmw_pkg::ByteWidth-1:0] byte_reg,    byte_next;
    logic [i2cmw_pkg::DataWidth-1:0] shift_reg,   shift_next;
    logic [i2cmw_pkg::DataWidth-1:0] payload_reg, payload_next;
    logic                            func_reg,    func_next;
    logic [i2cmw_pkg::MaskWidth-1:0] ack_reg,     ack_next;
    logic                            scl_reg,     scl_next;
    logic                            sda_reg,     sda_next;
    logic                            done_reg,    done_next;
    logic                            valid_reg,   valid_next;

    logic                            accept;
    logic                            enter;
    logic                            phase_end;
    logic [i2cmw_pkg::DataWidth-1:0] limit;
    logic [i2cmw_pkg::DataWidth:0]   tick_inc;

    // The state registers double as the result register; they move only on accept
    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign limit     = (cfg.delay_ticks == '0) ? i2cmw_pkg::DataWidth'(1) : cfg.delay_ticks;
    assign tick_inc  = {1'b0, tick_reg} + (i2cmw_pkg::DataWidth+1)'(1);
    assign phase_end = tick_inc >= {1'b0, limit};

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        payload_next = payload_reg;
        func_next    = func_reg;
        ack_next     = ack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done_next    = 1'b0;
        enter        = 1'b0;

        if (phase_reg == i2cmw_pkg::PH_IDLE)
        begin
            if (start_req)
            begin
                func_next    = func;
                payload_next = payload;
                shift_next   = cfg.device_address;
                bit_next     = '0;
                byte_next    = '0;
                ack_next     = '0;
                phase_next   = i2cmw_pkg::PH_S1;
                enter        = 1'b1;
            end
        end
        else if (!phase_end)
        begin
            tick_next = tick_inc[i2cmw_pkg::DataWidth-1:0];
        end
        else
        begin
            enter = 1'b1;
            case (phase_reg)
                i2cmw_pkg::PH_S1: phase_next = i2cmw_pkg::PH_S2;
                i2cmw_pkg::PH_S2: phase_next = i2cmw_pkg::PH_S3;
                i2cmw_pkg::PH_S3: phase_next = i2cmw_pkg::PH_B1;
                i2cmw_pkg::PH_B1: phase_next = i2cmw_pkg::PH_B2;
                i2cmw_pkg::PH_B2: phase_next = i2cmw_pkg::PH_B3;
                i2cmw_pkg::PH_B3:
                begin
                    if (bit_reg == i2cmw_pkg::LastBit)
                    begin
                        bit_next   = '0;
                        phase_next = i2cmw_pkg::PH_A1;
                    end
                    else
                    begin
                        bit_next   = bit_reg + i2cmw_pkg::BitWidth'(1);
                        shift_next = {shift_reg[i2cmw_pkg::DataWidth-2:0], 1'b0};
                        phase_next = i2cmw_pkg::PH_B1;
                    end
                end
                i2cmw_pkg::PH_A1: phase_next = i2cmw_pkg::PH_A2;
                i2cmw_pkg::PH_A2:
                begin
                    // Released SDA high at the ack clock means no acknowledge
                    if (sda_in)
                    begin
                        case (byte_reg)
                            2'd0:    ack_next = ack_reg | 3'b001;
                            2'd1:    ack_next = ack_reg | 3'b010;
                            2'd2:    ack_next = ack_reg | 3'b100;
                            default: ack_next = ack_reg;
                        endcase
                    end
                    phase_next = i2cmw_pkg::PH_A3;
                end
                i2cmw_pkg::PH_A3:
                begin
                    if (byte_reg >= i2cmw_pkg::LastByte)
                    begin
                        phase_next = i2cmw_pkg::PH_P1;
                    end
                    else
                    begin
                        byte_next = byte_reg + i2cmw_pkg::ByteWidth'(1);
                        if (byte_reg == '0)
                            shift_next = func_reg ? i2cmw_pkg::CtrlData
                                                  : i2cmw_pkg::CtrlCommand;
                        else
                            shift_next = payload_reg;
                        bit_next   = '0;
                        phase_next = i2cmw_pkg::PH_B1;
                    end
                end
                i2cmw_pkg::PH_P1:
                begin
                    phase_next = i2cmw_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                default: phase_next = i2cmw_pkg::PH_IDLE;
            endcase
        end

        // Bus levels are set on phase entry from the updated shift and bit count
        if (enter)
        begin
            tick_next = '0;
            case (phase_next)
                i2cmw_pkg::PH_S1: begin scl_next = 1'b1; sda_next = 1'b1; end
                i2cmw_pkg::PH_S2: begin scl_next = 1'b1; sda_next = 1'b0; end
                i2cmw_pkg::PH_S3: begin scl_next = 1'b0; sda_next = 1'b0; end
                i2cmw_pkg::PH_B1: begin scl_next = 1'b0; sda_next = shift_next[7]; end
                i2cmw_pkg::PH_B2: begin scl_next = 1'b1; sda_next = shift_next[7]; end
                i2cmw_pkg::PH_B3:
                begin
                    scl_next = 1'b0;
                    sda_next = (bit_next == i2cmw_pkg::LastBit) ? 1'b1 : shift_next[7];
                end
                i2cmw_pkg::PH_A1: begin scl_next = 1'b0; sda_next = 1'b1; end
                i2cmw_pkg::PH_A2: begin scl_next = 1'b1; sda_next = 1'b1; end
                i2cmw_pkg::PH_A3: begin scl_next = 1'b0; sda_next = 1'b1; end
                i2cmw_pkg::PH_P1: begin scl_next = 1'b1; sda_next = 1'b0; end
                default:          begin scl_next = 1'b1; sda_next = 1'b1; end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cmw_pkg::PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            payload_reg <= '0;
            func_reg    <= 1'b0;
            ack_reg     <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            done_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                bit_reg     <= bit_next;
                byte_reg    <= byte_next;
                shift_reg   <= shift_next;
                payload_reg <= payload_next;
                func_reg    <= func_next;
                ack_reg     <= ack_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                done_reg    <= done_next;
            end
        end
    end

    assign out_valid = valid_reg;
    assign scl_level = scl_reg;
    assign sda_level = sda_reg;
    assign busy_res  = phase_reg != i2cmw_pkg::PH_IDLE;
    assign done_res  = done_reg;
    assign nack_mask = ack_reg;

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_write_transaction.sv =====
// Each accepted item's result is registered and is valid in the following cycle.
// Throughput: one item per cycle; each item is one bus tick and leaves one result.
// The tick state registers also form the result register, so the input stalls
// only while a result is waiting and out_stall is high.
// Reset (rst_n low, asynchronous): bus idle with SCL and SDA released, no result
// pending, device_address 120 and delay_ticks 10.
`default_nettype none

module i2c_master_write_transaction
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                start_req,
    input  wire logic                                func,
    input  wire logic [i2cmw_pkg::DataWidth-1:0]     payload,
    input  wire logic                                sda_in,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     scl_level,
    output logic                                     sda_level,
    output logic                                     busy_res,
    output logic                                     done_res,
    output logic      [i2cmw_pkg::MaskWidth-1:0]     nack_mask,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [i2cmw_pkg::AddrWidth-1:0]     paddr,
    input  wire logic [i2cmw_pkg::BusWidth-1:0]      pwdata,
    output logic      [i2cmw_pkg::BusWidth-1:0]      prdata,
    output logic                                     pready
);

    i2cmw_pkg::cfg_t cfg;

    i2cmw_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cmw_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .func      (func),
        .payload   (payload),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .scl_level (scl_level),
        .sda_level (sda_level),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .nack_mask (nack_mask)
    );

endmodule

`default_nettype wire
